@@ rtl/core/cmb_pkg.sv @@
package cmb_pkg;

   localparam int MAG_W  = 25;   // magnitude of a centre difference
   localparam int PEN_W  = 25;   // penetration, Q16.9
   localparam int RAD_W  = 52;   // 4 * (dx*dx + dy*dy)
   localparam int ROOT_W = 26;   // distance, Q.9
   localparam int REM_W  = 28;   // square root remainder
   localparam int QUO_W  = 15;   // normal magnitude bits
   localparam int NRM_W  = 16;   // normal, Q1.14

   localparam logic signed [NRM_W-1:0] ONE_Q14 = 16'sd16384;

   typedef struct packed {
      logic                    hit;
      logic signed [NRM_W-1:0] nx;
      logic signed [NRM_W-1:0] ny;
      logic [PEN_W-1:0]        pen;
      logic                    use_div;
      logic                    sx;
      logic                    sy;
   } res_type;

   typedef struct packed {
      logic             mode;
      res_type          box;
      logic [MAG_W-1:0] ax;
      logic [MAG_W-1:0] ay;
      logic             sx;
      logic             sy;
      logic [PEN_W-1:0] rsum;
      logic [PEN_W-1:0] ra2;
   } side_type;

endpackage

@@ rtl/core/cmb_sqrt.sv @@
module cmb_sqrt import cmb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [RAD_W-1:0]  in_rad,
   input  side_type          in_side,
   output logic              out_valid,
   output logic [ROOT_W-1:0] out_root,
   output side_type          out_side
);

   localparam int N = ROOT_W;

   logic [N-1:0]       valid_ff;
   logic [REM_W-1:0]   rem_ff  [N];
   logic [ROOT_W-1:0]  root_ff [N];
   logic [RAD_W-1:0]   rad_ff  [N];
   side_type           side_ff [N];

   logic               cur_valid [N+1];
   logic [REM_W-1:0]   cur_rem   [N+1];
   logic [ROOT_W-1:0]  cur_root  [N+1];
   logic [RAD_W-1:0]   cur_rad   [N+1];
   side_type           cur_side  [N+1];

   assign cur_valid[0] = in_valid;
   assign cur_rem[0]   = '0;
   assign cur_root[0]  = '0;
   assign cur_rad[0]   = in_rad;
   assign cur_side[0]  = in_side;

   // one root bit per stage
   for (genvar k = 0; k < N; k++) begin : g_stage
      logic [REM_W+1:0]  trial;
      logic [REM_W+1:0]  sub;
      logic [REM_W+1:0]  diff;
      logic              ge;
      logic [REM_W-1:0]  rem_in;
      logic [ROOT_W-1:0] root_in;
      logic [RAD_W-1:0]  rad_in;

      always_comb begin
         trial   = {cur_rem[k], cur_rad[k][RAD_W-1 -: 2]};
         sub     = {{(REM_W-ROOT_W){1'b0}}, cur_root[k], 2'b01};
         diff    = trial - sub;
         ge      = (trial >= sub);
         rem_in  = ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
         root_in = {cur_root[k][ROOT_W-2:0], ge};
         rad_in  = {cur_rad[k][RAD_W-3:0], 2'b00};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= cur_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            root_ff[k] <= root_in;
            rad_ff[k]  <= rad_in;
            side_ff[k] <= cur_side[k];
         end
      end

      assign cur_valid[k+1] = valid_ff[k];
      assign cur_rem[k+1]   = rem_ff[k];
      assign cur_root[k+1]  = root_ff[k];
      assign cur_rad[k+1]   = rad_ff[k];
      assign cur_side[k+1]  = side_ff[k];
   end

   assign out_valid = cur_valid[N];
   assign out_root  = cur_root[N];
   assign out_side  = cur_side[N];

endmodule

@@ rtl/core/cmb_div.sv @@
module cmb_div import cmb_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [MAG_W-1:0]  in_num_x,
   input  logic [MAG_W-1:0]  in_num_y,
   input  logic [ROOT_W-1:0] in_den,
   input  res_type           in_res,
   output logic              out_valid,
   output logic [QUO_W-1:0]  out_quo_x,
   output logic [QUO_W-1:0]  out_quo_y,
   output res_type           out_res
);

   localparam int N = QUO_W;

   logic [N-1:0]       valid_ff;
   logic [ROOT_W-1:0]  den_ff [N];
   res_type            res_ff [N];
   logic [ROOT_W-1:0]  rem_ff [N][2];
   logic [QUO_W-1:0]   quo_ff [N][2];

   logic               cur_valid [N+1];
   logic [ROOT_W-1:0]  cur_den   [N+1];
   res_type            cur_res   [N+1];
   logic [ROOT_W-1:0]  cur_rem   [N+1][2];
   logic [QUO_W-1:0]   cur_quo   [N+1][2];

   assign cur_valid[0]  = in_valid;
   assign cur_den[0]    = in_den;
   assign cur_res[0]    = in_res;
   assign cur_rem[0][0] = {{(ROOT_W-MAG_W){1'b0}}, in_num_x};
   assign cur_rem[0][1] = {{(ROOT_W-MAG_W){1'b0}}, in_num_y};
   assign cur_quo[0][0] = '0;
   assign cur_quo[0][1] = '0;

   // restoring division, one quotient bit per stage; remainder stays below den
   for (genvar k = 0; k < N; k++) begin : g_stage
      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= cur_valid[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            den_ff[k] <= cur_den[k];
            res_ff[k] <= cur_res[k];
         end
      end

      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic [ROOT_W:0]   shifted;
         logic [ROOT_W:0]   diff;
         logic              ge;
         logic [ROOT_W-1:0] rem_in;
         logic [QUO_W-1:0]  quo_in;

         always_comb begin
            shifted = {cur_rem[k][l], 1'b0};
            diff    = shifted - {1'b0, cur_den[k]};
            ge      = (shifted >= {1'b0, cur_den[k]});
            rem_in  = ge ? diff[ROOT_W-1:0] : shifted[ROOT_W-1:0];
            quo_in  = {cur_quo[k][l][QUO_W-2:0], ge};
         end

         always_ff @(posedge clock) begin
            if (en) begin
               rem_ff[k][l] <= rem_in;
               quo_ff[k][l] <= quo_in;
            end
         end

         assign cur_rem[k+1][l] = rem_ff[k][l];
         assign cur_quo[k+1][l] = quo_ff[k][l];
      end

      assign cur_valid[k+1] = valid_ff[k];
      assign cur_den[k+1]   = den_ff[k];
      assign cur_res[k+1]   = res_ff[k];
   end

   assign out_valid = cur_valid[N];
   assign out_quo_x = cur_quo[N][0];
   assign out_quo_y = cur_quo[N][1];
   assign out_res   = cur_res[N];

endmodule

@@ rtl/core/contact_manifold_box_circle_unit.sv @@
// Contact manifold for one pair of bodies per request, box against box or
// circle against circle, with no state kept between requests.
// req channel: req_tuser carries the mode (0 box, 1 circle), req_tdata the
// centres and sizes. rsp channel: rsp_tuser carries the hit flag, rsp_tdata
// the Q1.14 normal and the Q16.9 penetration.
// Throughput: one request per cycle, sustained, as long as the receiver takes
// results. A result passes through one input stage, three stages of
// differences, overlaps and squares, one radicand stage, 26 square root
// stages (one root bit each), 15 divider stages (one normal bit each, x and
// y in parallel) and the output register.
// The square root chain sets the depth.
// When rsp_tready is low the output register holds its result and one more
// result lands in a skid register; then req_tready drops and the whole
// pipeline freezes, losing nothing. req_tready is driven from a register.
// Reset empties every stage, the output and the skid register; the block
// takes requests in the first cycle after reset is released.
module contact_manifold_box_circle_unit import cmb_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // centre_a_x, centre_a_y, centre_b_x, centre_b_y, width_a, height_a,
   // width_b, height_b, radius_a, radius_b, zero pad
   input  logic [239:0] req_tdata,
   // mode
   input  logic         req_tuser,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // normal_x, normal_y, penetration, zero pad
   output logic [63:0]  rsp_tdata,
   // hit
   output logic         rsp_tuser
);

   logic en;

   // stage 1: input register
   logic         v1_ff;
   logic         mode1_ff;
   logic [23:0]  cax1_ff, cay1_ff, cbx1_ff, cby1_ff;
   logic [22:0]  wa1_ff, ha1_ff, wb1_ff, hb1_ff, ra1_ff, rb1_ff;

   // stage 2: differences and sums
   logic                    v2_ff, mode2_ff;
   logic signed [MAG_W-1:0] dx2_ff, dy2_ff;
   logic [23:0]             wsum2_ff, hsum2_ff;
   logic [PEN_W-1:0]        rsum2_ff, ra2_2_ff;

   // stage 3: magnitudes and overlaps
   logic              v3_ff, mode3_ff, sx3_ff, sy3_ff;
   logic [MAG_W-1:0]  ax3_ff, ay3_ff;
   logic signed [26:0] ox3_ff, oy3_ff;
   logic [PEN_W-1:0]  rsum3_ff, ra2_3_ff;
   logic [MAG_W-1:0]  ax3_in, ay3_in;

   // stage 4: squares and box result
   logic                 v4_ff;
   logic [2*MAG_W-1:0]   ax2_4_ff, ay2_4_ff;
   side_type             side4_ff;
   res_type              box_in;

   // stage 5: radicand
   logic                 v5_ff;
   logic [RAD_W-1:0]     rad5_ff;
   side_type             side5_ff;
   logic [2*MAG_W:0]     sq_sum;

   logic                 sq_valid;
   logic [ROOT_W-1:0]    sq_root;
   side_type             sq_side;
   res_type              circ_res;

   logic                 dv_valid;
   logic [QUO_W-1:0]     dv_quo_x, dv_quo_y;
   res_type              dv_res;
   res_type              fin;
   logic signed [NRM_W-1:0] qx_s, qy_s;

   logic     out_valid_ff, skid_full_ff;
   res_type  out_ff, skid_ff;
   logic     pop;

   assign en         = !skid_full_ff;
   assign req_tready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= req_tvalid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
         v5_ff <= v4_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode1_ff <= req_tuser;
         cax1_ff  <= req_tdata[23:0];
         cay1_ff  <= req_tdata[47:24];
         cbx1_ff  <= req_tdata[71:48];
         cby1_ff  <= req_tdata[95:72];
         wa1_ff   <= req_tdata[118:96];
         ha1_ff   <= req_tdata[141:119];
         wb1_ff   <= req_tdata[164:142];
         hb1_ff   <= req_tdata[187:165];
         ra1_ff   <= req_tdata[210:188];
         rb1_ff   <= req_tdata[233:211];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mode2_ff <= mode1_ff;
         dx2_ff   <= $signed({cbx1_ff[23], cbx1_ff}) - $signed({cax1_ff[23], cax1_ff});
         dy2_ff   <= $signed({cby1_ff[23], cby1_ff}) - $signed({cay1_ff[23], cay1_ff});
         wsum2_ff <= {1'b0, wa1_ff} + {1'b0, wb1_ff};
         hsum2_ff <= {1'b0, ha1_ff} + {1'b0, hb1_ff};
         rsum2_ff <= {({1'b0, ra1_ff} + {1'b0, rb1_ff}), 1'b0};
         ra2_2_ff <= {1'b0, ra1_ff, 1'b0};
      end
   end

   always_comb begin
      ax3_in = dx2_ff[MAG_W-1] ? MAG_W'(0) - dx2_ff : dx2_ff;
      ay3_in = dy2_ff[MAG_W-1] ? MAG_W'(0) - dy2_ff : dy2_ff;
   end

   // overlaps at Q.9: size sum minus twice the distance
   always_ff @(posedge clock) begin
      if (en) begin
         mode3_ff <= mode2_ff;
         sx3_ff   <= dx2_ff[MAG_W-1];
         sy3_ff   <= dy2_ff[MAG_W-1];
         ax3_ff   <= ax3_in;
         ay3_ff   <= ay3_in;
         ox3_ff   <= $signed({3'b000, wsum2_ff}) - $signed({1'b0, ax3_in, 1'b0});
         oy3_ff   <= $signed({3'b000, hsum2_ff}) - $signed({1'b0, ay3_in, 1'b0});
         rsum3_ff <= rsum2_ff;
         ra2_3_ff <= ra2_2_ff;
      end
   end

   // ties go to y
   always_comb begin
      box_in         = '0;
      box_in.sx      = sx3_ff;
      box_in.sy      = sy3_ff;
      if ((ox3_ff > 0) && (oy3_ff > 0)) begin
         box_in.hit = 1'b1;
         if (ox3_ff < oy3_ff) begin
            box_in.nx  = sx3_ff ? -ONE_Q14 : ONE_Q14;
            box_in.pen = ox3_ff[PEN_W-1:0];
         end else begin
            box_in.ny  = sy3_ff ? -ONE_Q14 : ONE_Q14;
            box_in.pen = oy3_ff[PEN_W-1:0];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ax2_4_ff      <= ax3_ff * ax3_ff;
         ay2_4_ff      <= ay3_ff * ay3_ff;
         side4_ff.mode <= mode3_ff;
         side4_ff.box  <= box_in;
         side4_ff.ax   <= ax3_ff;
         side4_ff.ay   <= ay3_ff;
         side4_ff.sx   <= sx3_ff;
         side4_ff.sy   <= sy3_ff;
         side4_ff.rsum <= rsum3_ff;
         side4_ff.ra2  <= ra2_3_ff;
      end
   end

   assign sq_sum = {1'b0, ax2_4_ff} + {1'b0, ay2_4_ff};

   always_ff @(posedge clock) begin
      if (en) begin
         rad5_ff  <= {sq_sum[RAD_W-3:0], 2'b00};
         side5_ff <= side4_ff;
      end
   end

   cmb_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (v5_ff),
      .in_rad   (rad5_ff),
      .in_side  (side5_ff),
      .out_valid(sq_valid),
      .out_root (sq_root),
      .out_side (sq_side)
   );

   always_comb begin
      circ_res    = '0;
      circ_res.sx = sq_side.sx;
      circ_res.sy = sq_side.sy;
      if (!sq_side.mode) begin
         circ_res = sq_side.box;
      end else if ({1'b0, sq_side.rsum} >= sq_root) begin
         circ_res.hit = 1'b1;
         // coincident centres
         if (sq_root == '0) begin
            circ_res.nx  = ONE_Q14;
            circ_res.pen = sq_side.ra2;
         end else begin
            circ_res.pen     = PEN_W'({1'b0, sq_side.rsum} - sq_root);
            circ_res.use_div = 1'b1;
         end
      end
   end

   cmb_div u_div (
      .clock    (clock),
      .reset    (reset),
      .en       (en),
      .in_valid (sq_valid),
      .in_num_x (sq_side.ax),
      .in_num_y (sq_side.ay),
      .in_den   (sq_root),
      .in_res   (circ_res),
      .out_valid(dv_valid),
      .out_quo_x(dv_quo_x),
      .out_quo_y(dv_quo_y),
      .out_res  (dv_res)
   );

   always_comb begin
      qx_s = $signed({1'b0, dv_quo_x});
      qy_s = $signed({1'b0, dv_quo_y});
      fin  = dv_res;
      if (dv_res.use_div) begin
         fin.nx = dv_res.sx ? -qx_s : qx_s;
         fin.ny = dv_res.sy ? -qy_s : qy_s;
      end
   end

   assign pop = out_valid_ff && rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else if (skid_full_ff) begin
         if (pop) begin
            skid_full_ff <= 1'b0;
         end
      end else if (dv_valid) begin
         if (out_valid_ff && !rsp_tready) begin
            skid_full_ff <= 1'b1;
         end else begin
            out_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_full_ff) begin
         if (pop) begin
            out_ff <= skid_ff;
         end
      end else if (dv_valid) begin
         if (out_valid_ff && !rsp_tready) begin
            skid_ff <= fin;
         end else begin
            out_ff <= fin;
         end
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_ff.hit;
   assign rsp_tdata  = {7'b0, out_ff.pen, out_ff.ny, out_ff.nx};

endmodule

@@ verif/contact_manifold_box_circle_unit_tb.sv @@
`timescale 1ns / 100ps

module contact_manifold_box_circle_unit_tb import cmb_pkg::*; ();

   localparam logic MODE_BOX    = 1'b0;
   localparam logic MODE_CIRCLE = 1'b1;
   localparam int   PEN_SAT     = 33554431;
   localparam int   LATENCY     = 46;
   localparam int   WATCHDOG    = 20000;
   localparam int   N_RANDOM    = 700;

   typedef struct {
      logic              mode;
      logic signed [23:0] ax, ay, bx, by;
      logic [22:0]       wa, ha, wb, hb, ra, rb;
   } pair_type;

   typedef struct packed {
      logic              hit;
      logic signed [15:0] nx;
      logic signed [15:0] ny;
      logic [24:0]       pen;
   } manifold_type;

   logic         clock = 1'b0;
   logic         reset = 1'b1;
   logic         req_tvalid = 1'b0;
   logic         req_tready;
   logic [239:0] req_tdata = '0;
   logic         req_tuser = 1'b0;
   logic         rsp_tvalid;
   logic         rsp_tready = 1'b0;
   logic [63:0]  rsp_tdata;
   logic         rsp_tuser;

   manifold_type manifolds_due[$];
   pair_type     table_in[$];
   manifold_type table_want[$];
   bit           table_typed[$];
   int           errors = 0;
   int           idle_cycles = 0;
   bit           long_hold = 1'b0;

   contact_manifold_box_circle_unit u_dut (.*);

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   function automatic logic [63:0] floor_root(logic [63:0] v);
      logic [63:0] res;
      logic [63:0] b;
      res = 0;
      b = 64'd1 << 62;
      while (b > v) b >>= 2;
      while (b != 0) begin
         if (v >= res + b) begin
            v -= res + b;
            res = (res >> 1) + b;
         end else begin
            res >>= 1;
         end
         b >>= 2;
      end
      return res;
   endfunction

   function automatic manifold_type contact_of(pair_type p);
      manifold_type m;
      longint dx, dy, ox, oy, mx, my;
      longint unsigned root_dist, rsum, pen, qx, qy;
      m = '{hit: 1'b0, nx: '0, ny: '0, pen: '0};
      dx = longint'(p.bx) - longint'(p.ax);
      dy = longint'(p.by) - longint'(p.ay);
      mx = dx < 0 ? -dx : dx;
      my = dy < 0 ? -dy : dy;
      pen = 0;
      if (p.mode == MODE_BOX) begin
         ox = longint'(p.wa) + longint'(p.wb) - 2 * mx;
         oy = longint'(p.ha) + longint'(p.hb) - 2 * my;
         if (ox > 0 && oy > 0) begin
            m.hit = 1'b1;
            if (ox < oy) begin
               m.nx = dx < 0 ? -ONE_Q14 : ONE_Q14;
               pen = ox;
            end else begin
               m.ny = dy < 0 ? -ONE_Q14 : ONE_Q14;
               pen = oy;
            end
         end
      end else begin
         root_dist = floor_root(4 * (mx * mx + my * my));
         rsum = 2 * (longint'(p.ra) + longint'(p.rb));
         if (rsum >= root_dist) begin
            m.hit = 1'b1;
            if (root_dist != 0) begin
               pen = rsum - root_dist;
               qx = (mx * 32768) / root_dist;
               qy = (my * 32768) / root_dist;
               m.nx = 16'(dx < 0 ? -qx : qx);
               m.ny = 16'(dy < 0 ? -qy : qy);
            end else begin
               // coincident centres
               pen = 2 * longint'(p.ra);
               m.nx = ONE_Q14;
            end
         end
      end
      m.pen = 25'(pen > PEN_SAT ? PEN_SAT : pen);
      return m;
   endfunction

   function automatic pair_type random_pair();
      pair_type p;
      int span;
      p.mode = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 3))
         0: span = 23;
         1: span = 16;
         default: span = 12;
      endcase
      p.ax = 24'($signed($urandom) >>> (32 - span - 1));
      p.ay = 24'($signed($urandom) >>> (32 - span - 1));
      // keep B near A most of the time so contacts happen
      if ($urandom_range(0, 3) != 0) begin
         p.bx = p.ax + 24'($signed($urandom) >>> (32 - span));
         p.by = p.ay + 24'($signed($urandom) >>> (32 - span));
      end else begin
         p.bx = 24'($urandom);
         p.by = 24'($urandom);
      end
      p.wa = 23'($urandom >> (32 - span));
      p.ha = 23'($urandom >> (32 - span));
      p.wb = 23'($urandom >> (32 - span));
      p.hb = 23'($urandom >> (32 - span));
      p.ra = 23'($urandom >> (32 - span));
      p.rb = 23'($urandom >> (32 - span));
      if ($urandom_range(0, 15) == 0) begin
         p.wa = 23'($urandom); p.ha = 23'($urandom);
         p.wb = 23'($urandom); p.hb = 23'($urandom);
         p.ra = 23'($urandom); p.rb = 23'($urandom);
      end
      if ($urandom_range(0, 31) == 0) begin
         p.bx = p.ax;
         p.by = p.ay;
      end
      return p;
   endfunction

   task automatic add_row(pair_type p, bit typed, manifold_type want);
      table_in.push_back(p);
      table_typed.push_back(typed);
      table_want.push_back(want);
   endtask

   // req_tvalid stays high after the request is taken; the next call drops it only if it waits a gap
   task automatic send_pair(pair_type p, bit pace);
      int gap;
      gap = 0;
      if (pace) begin
         gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         if ($urandom_range(0, 2) == 0) gap = 0;
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= p.mode;
      req_tdata  <= {6'd0, p.rb, p.ra, p.hb, p.wb, p.ha, p.wa, p.by, p.bx, p.ay, p.ax};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   // expectation is queued when the request is taken
   always @(posedge clock) begin
      if (!reset && req_tvalid && req_tready) begin
         pair_type p;
         p.mode = req_tuser;
         {p.rb, p.ra, p.hb, p.wb, p.ha, p.wa, p.by, p.bx, p.ay, p.ax} = req_tdata[233:0];
         manifolds_due.push_back(contact_of(p));
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         manifold_type e;
         if (manifolds_due.size() == 0) begin
            $error("result with nothing expected");
            errors++;
         end else begin
            e = manifolds_due.pop_front();
            if (rsp_tuser !== e.hit) begin
               $error("hit: expected %0d got %0d", e.hit, rsp_tuser);
               errors++;
            end
            if (rsp_tdata[15:0] !== e.nx) begin
               $error("normal_x: expected %0d got %0d", e.nx, $signed(rsp_tdata[15:0]));
               errors++;
            end
            if (rsp_tdata[31:16] !== e.ny) begin
               $error("normal_y: expected %0d got %0d", e.ny, $signed(rsp_tdata[31:16]));
               errors++;
            end
            if (rsp_tdata[56:32] !== e.pen) begin
               $error("penetration: expected %0d got %0d", e.pen, rsp_tdata[56:32]);
               errors++;
            end
            if (rsp_tdata[63:57] !== '0) begin
               $error("pad: expected 0 got %0h", rsp_tdata[63:57]);
               errors++;
            end
         end
      end
   end

   // receiver stalls
   initial begin
      int hold;
      bit held;
      held = 1'b0;
      @(negedge reset);
      forever begin
         if (long_hold && !held) begin
            rsp_tready <= 1'b0;
            repeat (200) @(posedge clock);
            held = 1'b1;
         end
         hold = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 16);
         if ($urandom_range(0, 2) == 0) hold = 0;
         if (hold > 0) begin
            rsp_tready <= 1'b0;
            repeat (hold) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
      end
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG) begin
         $display("contact_manifold_box_circle_unit_tb: done, errors");
         $finish;
      end
   end

   initial begin
      pair_type p;
      manifold_type none, want;
      none = '{hit: 1'b0, nx: '0, ny: '0, pen: '0};
      p = '{mode: MODE_BOX, ax: '0, ay: '0, bx: '0, by: '0,
            wa: '0, ha: '0, wb: '0, hb: '0, ra: '0, rb: '0};
      // all zero box: no overlap
      add_row(p, 1, none);
      // box tie goes to y
      p.wa = 256; p.ha = 256; p.wb = 256; p.hb = 256;
      want = '{hit: 1'b1, nx: '0, ny: ONE_Q14, pen: 512};
      add_row(p, 1, want);
      // x wins, negative side
      p.bx = -24'sd10; p.ha = 2000;
      want = '{hit: 1'b1, nx: -ONE_Q14, ny: '0, pen: 492};
      add_row(p, 1, want);
      p.bx = 10; add_row(p, 0, none);
      p.by = -24'sd5; p.bx = 0; p.wa = 4000; add_row(p, 0, none);
      // touching edges: not a hit
      p.bx = 256; p.by = 0; p.wa = 256; p.ha = 256; add_row(p, 1, none);
      // largest boxes, full overlap
      p.bx = 0; p.wa = '1; p.ha = '1; p.wb = '1; p.hb = '1;
      want = '{hit: 1'b1, nx: '0, ny: ONE_Q14, pen: 25'd16777214};
      add_row(p, 1, want);
      // extremes of centres
      p.ax = 24'sh800000; p.ay = 24'sh7fffff; p.bx = 24'sh7fffff; p.by = 24'sh800000;
      add_row(p, 0, none);
      p.ra = '1; p.rb = '1; add_row(p, 0, none);
      // circles
      p = '{mode: MODE_CIRCLE, ax: '0, ay: '0, bx: '0, by: '0,
            wa: '1, ha: '1, wb: '1, hb: '1, ra: '0, rb: '0};
      // coincident, zero radii
      want = '{hit: 1'b1, nx: ONE_Q14, ny: '0, pen: '0};
      add_row(p, 1, want);
      p.ra = 300; p.rb = 7;
      want = '{hit: 1'b1, nx: ONE_Q14, ny: '0, pen: 600};
      add_row(p, 1, want);
      p.bx = 256; p.ra = 256; p.rb = 256;
      want = '{hit: 1'b1, nx: ONE_Q14, ny: '0, pen: 512};
      add_row(p, 1, want);
      p.bx = -24'sd300; p.by = 400; add_row(p, 0, none);
      p.bx = 3; p.by = -24'sd4; p.ra = 0; p.rb = 0; add_row(p, 1, none);
      p.ra = 3; add_row(p, 0, none);
      p.ax = 24'sh800000; p.ay = 24'sh800000; p.bx = 24'sh7fffff; p.by = 24'sh7fffff;
      p.ra = '1; p.rb = '1; add_row(p, 0, none);
      p.ra = 0; add_row(p, 0, none);
      p.ax = 0; p.ay = 0; p.bx = 0; p.by = 0; p.ra = '1;
      want = '{hit: 1'b1, nx: ONE_Q14, ny: '0, pen: 2 * 23'h7fffff};
      add_row(p, 1, want);

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < table_in.size(); i++) begin
         if (table_typed[i] && contact_of(table_in[i]) != table_want[i]) begin
            $error("typed row %0d disagrees with prediction", i);
            errors++;
         end
         send_pair(table_in[i], 1'b1);
      end
      // pause until everything is back
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (manifolds_due.size() != 0) @(posedge clock);
      for (int i = 0; i < N_RANDOM; i++) begin
         if (i == 100) long_hold = 1'b1;
         // back to back so the pipe fills behind the stalled receiver
         send_pair(random_pair(), !(i >= 100 && i < 180));
      end
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (manifolds_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 10) @(posedge clock);
      if (errors == 0 && manifolds_due.size() == 0)
         $display("contact_manifold_box_circle_unit_tb: done, clean");
      else
         $display("contact_manifold_box_circle_unit_tb: done, errors");
      $finish;
   end

endmodule
